### design/szsm_pkg.sv
// Shared constants and codes of the sparse ZSSD stereo matcher.
package szsm_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_WR_LEFT  = 2'd0;
  localparam logic [1:0] FUNC_WR_RIGHT = 2'd1;
  localparam logic [1:0] FUNC_MATCH    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_INACTIVE = 3'd1;
  localparam logic [2:0] STAT_BORDER   = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_REJECT   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_DISP_MIN    = 3'd0;
  localparam logic [2:0] CFG_DISP_MAX    = 3'd1;
  localparam logic [2:0] CFG_MASK_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_MASK_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_CHECK_VAR   = 3'd4;
  localparam logic [2:0] CFG_MIN_VAR     = 3'd5;
  localparam logic [2:0] CFG_MAX_ZSSD    = 3'd6;
  localparam logic [2:0] CFG_MAX_SSD     = 3'd7;

  // Field and datapath widths
  localparam int POS_W      = 11;
  localparam int PIX_W      = 8;
  localparam int DQ_W       = 13;
  localparam int ST_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int N_W        = 8;   // pixels in window, up to 225
  localparam int SUM_W      = 16;  // window sum of luminance
  localparam int SS_W       = 24;  // window sum of squares
  localparam int Z_W        = 32;  // N-scaled scores
  localparam int THZ_W      = 40;
  localparam int DIV_W      = 40;
  localparam int QUO_W      = 4;

endpackage

### design/szsm_if.sv
// Handshake channels of the stereo matcher: input items, results, configuration.
interface szsm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [szsm_pkg::POS_W-1:0]    pos_x;
  logic [szsm_pkg::POS_W-1:0]    pos_y;
  logic [szsm_pkg::PIX_W-1:0]    pixel;
  logic                          feature_active;

  modport source (output valid, func, pos_x, pos_y, pixel, feature_active, input ready);
  modport sink (input valid, func, pos_x, pos_y, pixel, feature_active, output ready);
endinterface

interface szsm_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [szsm_pkg::DQ_W-1:0] disparity_q4;
  logic [szsm_pkg::ST_W-1:0]     status;
  logic                          subpixel_applied;

  modport source (output valid, disparity_q4, status, subpixel_applied, input ready);
  modport sink (input valid, disparity_q4, status, subpixel_applied, output ready);
endinterface

interface szsm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [szsm_pkg::CFG_IDX_W-1:0]    index;
  logic [szsm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/szsm_frame.sv
// Frame store: one write port, one read port with registered read data.
module szsm_frame #(
  parameter int DEPTH = 307200
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  logic [szsm_pkg::PIX_W-1:0]   wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output logic [szsm_pkg::PIX_W-1:0]   rdata_o
);

  logic [szsm_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [szsm_pkg::PIX_W-1:0] rdata_q;

  // Store pixel beats
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the addressed pixel
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/szsm_div.sv
// Restoring divider for the sub-pixel step: small quotient, one bit a cycle.
module szsm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [szsm_pkg::DIV_W-1:0]  num_i,
  input  logic [szsm_pkg::DIV_W-1:0]  den_i,
  output logic                        done_o,
  output logic [szsm_pkg::QUO_W-1:0]  quo_o
);

  localparam int BW = $clog2(szsm_pkg::QUO_W);

  logic                        busy_q;
  logic                        done_q;
  logic [BW-1:0]               bit_q;
  logic [szsm_pkg::DIV_W-1:0]  rem_q;
  logic [szsm_pkg::DIV_W-1:0]  dv_q;
  logic [szsm_pkg::QUO_W-1:0]  quo_q;
  logic [szsm_pkg::DIV_W-1:0]  shifted;

  assign shifted = dv_q << bit_q;

  // Compare and subtract one quotient bit per cycle, top bit first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
      rem_q  <= '0;
      dv_q   <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      bit_q  <= BW'(szsm_pkg::QUO_W - 1);
      rem_q  <= num_i;
      dv_q   <= den_i;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_q        <= rem_q - shifted;
        quo_q[bit_q] <= 1'b1;
      end
      if (bit_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        bit_q <= bit_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### design/sparse_zssd_stereo_matcher.sv
// Sparse ZSSD stereo matcher: pixel beats (func 0/1) fill the left and right frame stores,
// one pixel per cycle while the matcher is idle, and give no result. A match beat (func 2)
// gives one result. A match runs the setup states (mask, geometry, window size squared,
// thresholds), then scans the w x h window for each candidate column, where w x h is the
// corrected window size and the candidates are the disparity range widened by one on each
// side and clipped to the image, then runs the tests and the sub-pixel division. The scan
// pace is set by the single read port of each frame store, one window pixel per cycle. Early
// statuses (inactive, border, empty range) skip the scan and go straight to the output.
// One item is worked at a time; a finished result waits in an output register while the
// next beat is taken.
module sparse_zssd_stereo_matcher #(
  parameter int IMG_WIDTH  = 640,
  parameter int IMG_HEIGHT = 480,
  parameter int MASK_MAX   = 15,
  parameter int DISP_LIMIT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  szsm_in_if.sink      in_i,
  szsm_out_if.source   out_o,
  szsm_cfg_if.sink     cfg_i
);

  localparam int DEPTH    = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW       = $clog2(DEPTH);
  localparam int KW       = $clog2(DISP_LIMIT + 3);
  localparam int CW       = 14;
  localparam int MASK_CAP = (MASK_MAX % 2 == 0) ? MASK_MAX - 1 : MASK_MAX;
  localparam int DLIM     = DISP_LIMIT - 1;
  localparam int PW       = szsm_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MASK, S_GEOM, S_NN, S_THR, S_SCAN, S_DRAIN, S_MUL,
    S_SCORE, S_FINAL, S_CHECK, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [7:0]  dmin_q, dmax_q;
  logic [3:0]  mw_q, mh_q;
  logic        chkv_q;
  logic [15:0] minv_q;
  logic [23:0] maxz_q, maxs_q;

  // Match item and derived geometry
  logic [PW-1:0]  x_q, y_q;
  logic           act_q;
  logic [3:0]     w_q, h_q, i_q, j_q;
  logic [2:0]     hw_q, hh_q;
  logic [szsm_pkg::N_W-1:0] n_q;
  logic [15:0]    nn_q;
  logic [szsm_pkg::THZ_W-1:0] thz_q;
  logic [31:0]    ths_q, thv_q;
  logic [PW-1:0]  rmin_q, rmax_q, c_q, bestc_q;
  logic [KW-1:0]  k_q;
  logic [AW-1:0]  row0_q, rowbase_q;

  // Window sums
  logic                        rd_vld_q;
  logic [szsm_pkg::SUM_W-1:0]  sl_q, sr_q;
  logic [szsm_pkg::SS_W-1:0]   ss_q, sr2_q;
  logic [31:0]                 p1_q, p2_q, p3_q, p4_q;

  // Best candidate and neighbor scores
  logic [szsm_pkg::Z_W-1:0]    bestz_q, bestv_q, prevz_q, cp_q, cm_q;
  logic [szsm_pkg::SS_W-1:0]   bests_q;
  logic                        needcm_q, pass_q;
  logic signed [34:0]          den_q;
  logic signed [33:0]          diff_q;

  // Pending result and output register
  logic signed [szsm_pkg::DQ_W-1:0] res_dq_q, out_dq_q;
  logic [szsm_pkg::ST_W-1:0]        res_st_q, out_st_q;
  logic                             res_sp_q, out_sp_q, out_vld_q;

  function automatic logic [3:0] fix_mask(input logic [3:0] m);
    logic [3:0] v;
    v = m | 4'd1;
    if (v < 4'd3) v = 4'd3;
    if (int'(v) > MASK_CAP) v = 4'(MASK_CAP);
    return v;
  endfunction

  // Handshakes
  logic accept, wr_in_range;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign wr_in_range = (int'(in_i.pos_x) < IMG_WIDTH) && (int'(in_i.pos_y) < IMG_HEIGHT);

  // Frame store ports
  logic          we_l, we_r;
  logic [AW-1:0] waddr, laddr, raddr;
  logic [7:0]    lpix, rpix;

  assign we_l  = accept && (in_i.func == szsm_pkg::FUNC_WR_LEFT) && wr_in_range;
  assign we_r  = accept && (in_i.func == szsm_pkg::FUNC_WR_RIGHT) && wr_in_range;
  assign waddr = AW'(32'(in_i.pos_y) * 32'(IMG_WIDTH) + 32'(in_i.pos_x));
  assign laddr = rowbase_q + AW'(PW'(x_q - PW'(hw_q) + PW'(j_q)));
  assign raddr = rowbase_q + AW'(PW'(c_q - PW'(hw_q) + PW'(j_q)));

  szsm_frame #(.DEPTH(DEPTH)) u_left (
    .clk_i(clk_i), .we_i(we_l), .waddr_i(waddr), .wdata_i(in_i.pixel),
    .raddr_i(laddr), .rdata_o(lpix)
  );

  szsm_frame #(.DEPTH(DEPTH)) u_right (
    .clk_i(clk_i), .we_i(we_r), .waddr_i(waddr), .wdata_i(in_i.pixel),
    .raddr_i(raddr), .rdata_o(rpix)
  );

  // Pixel difference terms
  logic [7:0]  ad;
  logic [15:0] sq_d, sq_r;
  assign ad   = (lpix > rpix) ? lpix - rpix : rpix - lpix;
  assign sq_d = 16'(ad) * 16'(ad);
  assign sq_r = 16'(rpix) * 16'(rpix);

  // Geometry of the search
  logic signed [CW-1:0] xs, ys, hws, hhs, dmn_s, dmx_s, rmin_s, rmax_s, rlim_s;
  logic                 outside, border;
  always_comb begin
    xs     = CW'(x_q);
    ys     = CW'(y_q);
    hws    = CW'(hw_q);
    hhs    = CW'(hh_q);
    dmn_s  = (int'(dmin_q) > DLIM) ? CW'(DLIM) : CW'(dmin_q);
    dmx_s  = (int'(dmax_q) > DLIM) ? CW'(DLIM) : CW'(dmax_q);
    rlim_s = CW'(IMG_WIDTH - 1) - hws;
    rmin_s = xs - dmx_s - CW'(1);
    if (rmin_s < hws) rmin_s = hws;
    rmax_s = xs - dmn_s + CW'(1);
    if (rmax_s > rlim_s) rmax_s = rlim_s;
    outside = !act_q || (int'(x_q) >= IMG_WIDTH) || (int'(y_q) >= IMG_HEIGHT);
    border  = (ys < hhs) || (ys + hhs >= CW'(IMG_HEIGHT)) ||
              (xs < hws) || (xs + hws >= CW'(IMG_WIDTH));
  end

  // Window score terms
  logic [15:0] dabs;
  logic [31:0] z, v;
  assign dabs = (sl_q >= sr_q) ? sl_q - sr_q : sr_q - sl_q;
  assign z    = p1_q - p2_q;
  assign v    = p3_q - p4_q;

  // Sub-pixel terms
  logic [32:0]                adiff;
  logic                       apply;
  logic                       div_start, div_done;
  logic [szsm_pkg::DIV_W-1:0] div_num, div_den;
  logic [szsm_pkg::QUO_W-1:0] quo;
  logic signed [15:0]         best_q4;
  logic signed [15:0]         rnd;

  assign adiff     = diff_q[33] ? 33'(-diff_q) : 33'(diff_q);
  assign apply     = (den_q > 35'sd0) && ($signed({2'b00, adiff}) <= den_q);
  assign div_start = (state_q == S_CHECK) && pass_q && apply;
  assign div_num   = (szsm_pkg::DIV_W'(adiff) << 4) + szsm_pkg::DIV_W'(den_q[33:0]);
  assign div_den   = szsm_pkg::DIV_W'(den_q[33:0]) << 1;
  assign best_q4   = (16'(x_q) - 16'(bestc_q)) <<< 4;
  assign rnd       = diff_q[33] ? -16'(quo) : 16'(quo);

  szsm_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(quo)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmin_q <= 8'd0;
      dmax_q <= 8'd80;
      mw_q   <= 4'd11;
      mh_q   <= 4'd11;
      chkv_q <= 1'b0;
      minv_q <= 16'd0;
      maxz_q <= 24'd10000000;
      maxs_q <= 24'd10000000;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        szsm_pkg::CFG_DISP_MIN:    dmin_q <= cfg_i.data[7:0];
        szsm_pkg::CFG_DISP_MAX:    dmax_q <= cfg_i.data[7:0];
        szsm_pkg::CFG_MASK_WIDTH:  mw_q   <= cfg_i.data[3:0];
        szsm_pkg::CFG_MASK_HEIGHT: mh_q   <= cfg_i.data[3:0];
        szsm_pkg::CFG_CHECK_VAR:   chkv_q <= cfg_i.data[0];
        szsm_pkg::CFG_MIN_VAR:     minv_q <= cfg_i.data[15:0];
        szsm_pkg::CFG_MAX_ZSSD:    maxz_q <= cfg_i.data[23:0];
        szsm_pkg::CFG_MAX_SSD:     maxs_q <= cfg_i.data[23:0];
        default: ;
      endcase
    end
  end

  // Match sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      needcm_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
      if (out_vld_q && out_o.ready && state_q != S_OUT) out_vld_q <= 1'b0;

      // Accumulate one window pixel pair per read
      if (rd_vld_q) begin
        sl_q  <= sl_q + szsm_pkg::SUM_W'(lpix);
        sr_q  <= sr_q + szsm_pkg::SUM_W'(rpix);
        ss_q  <= ss_q + szsm_pkg::SS_W'(sq_d);
        sr2_q <= sr2_q + szsm_pkg::SS_W'(sq_r);
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept && in_i.func == szsm_pkg::FUNC_MATCH) begin
            x_q     <= in_i.pos_x;
            y_q     <= in_i.pos_y;
            act_q   <= in_i.feature_active;
            state_q <= S_MASK;
          end
        end
        S_MASK: begin
          w_q     <= fix_mask(mw_q);
          h_q     <= fix_mask(mh_q);
          hw_q    <= 3'(fix_mask(mw_q) >> 1);
          hh_q    <= 3'(fix_mask(mh_q) >> 1);
          state_q <= S_GEOM;
        end
        S_GEOM: begin
          n_q       <= 8'(w_q) * 8'(h_q);
          rmin_q    <= PW'(rmin_s);
          rmax_q    <= PW'(rmax_s);
          c_q       <= PW'(rmin_s);
          k_q       <= '0;
          i_q       <= '0;
          j_q       <= '0;
          row0_q    <= AW'(32'(y_q - PW'(hh_q)) * 32'(IMG_WIDTH));
          rowbase_q <= AW'(32'(y_q - PW'(hh_q)) * 32'(IMG_WIDTH));
          sl_q      <= '0;
          sr_q      <= '0;
          ss_q      <= '0;
          sr2_q     <= '0;
          needcm_q  <= 1'b0;
          res_dq_q  <= '0;
          res_sp_q  <= 1'b0;
          priority if (outside) begin
            res_st_q <= szsm_pkg::STAT_INACTIVE;
            state_q  <= S_OUT;
          end else if (border) begin
            res_st_q <= szsm_pkg::STAT_BORDER;
            state_q  <= S_OUT;
          end else if (rmin_s >= rmax_s) begin
            res_st_q <= szsm_pkg::STAT_EMPTY;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_NN;
          end
        end
        S_NN: begin
          nn_q    <= 16'(n_q) * 16'(n_q);
          state_q <= S_THR;
        end
        S_THR: begin
          thz_q   <= szsm_pkg::THZ_W'(maxz_q) * szsm_pkg::THZ_W'(nn_q);
          ths_q   <= 32'(maxs_q) * 32'(n_q);
          thv_q   <= 32'(minv_q) * 32'(nn_q);
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // Issue one read per store; walk the window row by row
          if (j_q == w_q - 4'd1) begin
            j_q       <= '0;
            rowbase_q <= rowbase_q + AW'(IMG_WIDTH);
            if (i_q == h_q - 4'd1) begin
              state_q <= S_DRAIN;
            end else begin
              i_q <= i_q + 4'd1;
            end
          end else begin
            j_q <= j_q + 4'd1;
          end
        end
        S_DRAIN: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          p1_q    <= 32'(n_q) * 32'(ss_q);
          p2_q    <= 32'(dabs) * 32'(dabs);
          p3_q    <= 32'(n_q) * 32'(sr2_q);
          p4_q    <= 32'(sr_q) * 32'(sr_q);
          state_q <= S_SCORE;
        end
        S_SCORE: begin
          // Keep the first lowest score; catch its neighbor on the next candidate
          if (k_q == '0 || z < bestz_q) begin
            bestz_q  <= z;
            bests_q  <= ss_q;
            bestv_q  <= v;
            bestc_q  <= c_q;
            cp_q     <= prevz_q;
            needcm_q <= 1'b1;
          end else if (needcm_q) begin
            cm_q     <= z;
            needcm_q <= 1'b0;
          end
          prevz_q <= z;
          if (c_q == rmax_q) begin
            state_q <= S_FINAL;
          end else begin
            c_q       <= c_q + PW'(1);
            k_q       <= k_q + KW'(1);
            i_q       <= '0;
            j_q       <= '0;
            rowbase_q <= row0_q;
            sl_q      <= '0;
            sr_q      <= '0;
            ss_q      <= '0;
            sr2_q     <= '0;
            state_q   <= S_SCAN;
          end
        end
        S_FINAL: begin
          pass_q  <= (bestc_q > rmin_q) && (bestc_q < rmax_q) &&
                     (szsm_pkg::THZ_W'(bestz_q) < thz_q) &&
                     (32'(bests_q) < ths_q) &&
                     (!chkv_q || bestv_q > thv_q);
          den_q   <= 35'(cp_q) + 35'(cm_q) - (35'(bestz_q) << 1);
          diff_q  <= 34'(cm_q) - 34'(cp_q);
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          priority if (!pass_q) begin
            res_st_q <= szsm_pkg::STAT_REJECT;
            res_dq_q <= '0;
            res_sp_q <= 1'b0;
            state_q  <= S_OUT;
          end else if (apply) begin
            state_q <= S_DIV;
          end else begin
            res_st_q <= szsm_pkg::STAT_OK;
            res_dq_q <= best_q4[szsm_pkg::DQ_W-1:0];
            res_sp_q <= 1'b0;
            state_q  <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_st_q <= szsm_pkg::STAT_OK;
            res_dq_q <= 13'(best_q4 + rnd);
            res_sp_q <= 1'b1;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          // Hand over once the output register is free
          if (!out_vld_q || out_o.ready) begin
            out_vld_q <= 1'b1;
            out_dq_q  <= res_dq_q;
            out_st_q  <= res_st_q;
            out_sp_q  <= res_sp_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.disparity_q4     = out_dq_q;
  assign out_o.status           = out_st_q;
  assign out_o.subpixel_applied = out_sp_q;

  // Window reads only follow the scan state
  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == S_SCAN))
    else $error("window read outside scan");

  // Divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside wait state");

  // Best candidate stays inside the searched columns
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINAL |-> (bestc_q >= rmin_q && bestc_q <= rmax_q))
    else $error("best column outside search range");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready && state_q == S_OUT) |=> state_q == S_OUT)
    else $error("result dropped");

endmodule

### bench/szsm_tb_if.sv
// Bench types: the result beat of the matcher as the testbench predicts it.
`timescale 1ns / 1ps
package szsm_tb_types;

  // One result beat of the matcher as the bench predicts it
  typedef struct {
    logic signed [szsm_pkg::DQ_W-1:0] dq;
    logic [szsm_pkg::ST_W-1:0]        st;
    logic                             sp;
  } match_res_t;

endpackage

### bench/testbench.sv
// Testbench of the sparse ZSSD stereo matcher: frame fills, directed and random matches.
`timescale 1ns / 1ps
module testbench;

  localparam int IMG_W      = 640;
  localparam int IMG_H      = 480;
  localparam int MASK_LIM   = 15;
  localparam int SLOTS      = 259;
  localparam int REG_ROWS   = 16;   // written patch near the origin: rows 0..15
  localparam int REG_COLS   = 32;   // columns 0..31
  localparam int EDGE_COL0  = 624;  // written patch at the right edge, rows 0..2
  localparam int TRUE_SHIFT = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  szsm_in_if  in_bus();
  szsm_out_if out_bus();
  szsm_cfg_if cfg_bus();

  sparse_zssd_stereo_matcher u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow frame stores and register file
  logic [7:0]  left_img [IMG_W*IMG_H];
  logic [7:0]  right_img[IMG_W*IMG_H];
  logic [7:0]  r_dmin, r_dmax;
  logic [3:0]  r_mw, r_mh;
  logic        r_cvar;
  logic [15:0] r_minvar;
  logic [23:0] r_maxz, r_maxs;

  szsm_tb_types::match_res_t pending_q[$];
  int errors = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  // Clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int odd_window(int m);
    int v;
    v = m + 1 - (m % 2);
    if (v < 3) v = 3;
    if (v > MASK_LIM) begin
      v = MASK_LIM;
      if (v % 2 == 0) v = v - 1;
    end
    return v;
  endfunction

  // Work out the result of one match request against the shadow stores
  function automatic szsm_tb_types::match_res_t match_feature(int x, int y, bit act);
    int w, h, hw, hh, rmin, rmax, lo, hi, best, bestk, c, k, i, j, q;
    longint n, sl, sr, ss, sr2, z, bestz, bests, bestv;
    longint cp, cm, c0, den, diff, ad, num, rr, a, b;
    longint scores[SLOTS];
    bit have, ok;
    szsm_tb_types::match_res_t res;
    w = odd_window(r_mw);
    h = odd_window(r_mh);
    hw = w / 2;
    hh = h / 2;
    n = w * h;
    res.dq = '0;
    res.sp = 1'b0;
    res.st = szsm_pkg::STAT_OK;
    best = 0;
    bestk = 0;
    bestz = 0;
    bests = 0;
    bestv = 0;
    have = 1'b0;
    if (!act || x >= IMG_W || y >= IMG_H) begin
      res.st = szsm_pkg::STAT_INACTIVE;
      return res;
    end
    if (y - hh < 0 || y + hh >= IMG_H || x - hw < 0 || x + hw >= IMG_W) begin
      res.st = szsm_pkg::STAT_BORDER;
      return res;
    end
    rmin = x - int'(r_dmax) - 1;
    if (rmin < hw) rmin = hw;
    rmax = x - int'(r_dmin) + 1;
    if (rmax > IMG_W - 1 - hw) rmax = IMG_W - 1 - hw;
    if (rmin >= rmax) begin
      res.st = szsm_pkg::STAT_EMPTY;
      return res;
    end
    lo = x - rmax;
    hi = x - rmin;
    k = 0;
    for (c = rmin; c <= rmax && k < SLOTS; c++) begin
      sl = 0; sr = 0; ss = 0; sr2 = 0;
      for (i = y - hh; i <= y + hh; i++) begin
        for (j = 0; j < w; j++) begin
          a = left_img[i*IMG_W + x - hw + j];
          b = right_img[i*IMG_W + c - hw + j];
          sl += a;
          sr += b;
          ss += (a - b) * (a - b);
          sr2 += b * b;
        end
      end
      z = n * ss - (sl - sr) * (sl - sr);
      scores[k] = z;
      if (!have || z < bestz) begin
        have = 1'b1;
        bestz = z;
        bests = ss;
        best = x - c;
        bestk = k;
        bestv = n * sr2 - sr * sr;
      end
      k++;
    end
    ok = best > lo && best < hi && bestz < longint'(r_maxz) * n * n &&
         bests < longint'(r_maxs) * n &&
         (!r_cvar || bestv > longint'(r_minvar) * n * n);
    if (!ok || bestk < 1 || bestk + 1 >= SLOTS) begin
      res.st = szsm_pkg::STAT_REJECT;
      return res;
    end
    // Parabolic refinement around the best score
    cp = scores[bestk - 1];
    cm = scores[bestk + 1];
    c0 = bestz;
    den = cp + cm - 2 * c0;
    diff = cm - cp;
    ad = diff < 0 ? -diff : diff;
    q = best * 16;
    if (den > 0 && ad <= den) begin
      num = 8 * diff;
      if (num >= 0) rr = (2 * num + den) / (2 * den);
      else rr = -((-2 * num + den) / (2 * den));
      q = q + int'(rr);
      res.sp = 1'b1;
    end
    res.dq = q[szsm_pkg::DQ_W-1:0];
    return res;
  endfunction

  // Send one item beat and update the shadow state when it is taken
  task automatic send_item(logic [1:0] f, int x, int y, int pix, bit act);
    int gap;
    bit acc;
    gap = in_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.func           <= f;
    in_bus.pos_x          <= x[szsm_pkg::POS_W-1:0];
    in_bus.pos_y          <= y[szsm_pkg::POS_W-1:0];
    in_bus.pixel          <= pix[szsm_pkg::PIX_W-1:0];
    in_bus.feature_active <= act;
    do begin
      @(negedge clk_i);
      acc = in_bus.ready;
      @(posedge clk_i);
    end while (!acc);
    case (f)
      szsm_pkg::FUNC_WR_LEFT: begin
        if (x < IMG_W && y < IMG_H) left_img[y*IMG_W + x] = pix[7:0];
      end
      szsm_pkg::FUNC_WR_RIGHT: begin
        if (x < IMG_W && y < IMG_H) right_img[y*IMG_W + x] = pix[7:0];
      end
      szsm_pkg::FUNC_MATCH: pending_q.insert(pending_q.size(), match_feature(x, y, act));
      default: ;
    endcase
  endtask

  // Hold the input side until every expected result is in and the block is idle
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [szsm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    bit acc;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val[szsm_pkg::CFG_DATA_W-1:0];
    do begin
      @(negedge clk_i);
      acc = cfg_bus.ready;
      @(posedge clk_i);
    end while (!acc);
    case (idx)
      szsm_pkg::CFG_DISP_MIN:    r_dmin   = val[7:0];
      szsm_pkg::CFG_DISP_MAX:    r_dmax   = val[7:0];
      szsm_pkg::CFG_MASK_WIDTH:  r_mw     = val[3:0];
      szsm_pkg::CFG_MASK_HEIGHT: r_mh     = val[3:0];
      szsm_pkg::CFG_CHECK_VAR:   r_cvar   = val[0];
      szsm_pkg::CFG_MIN_VAR:     r_minvar = val[15:0];
      szsm_pkg::CFG_MAX_ZSSD:    r_maxz   = val[23:0];
      szsm_pkg::CFG_MAX_SSD:     r_maxs   = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int dmin, int dmax, int mw, int mh, int cv, int mv, int mz,
                            int ms);
    write_reg(szsm_pkg::CFG_DISP_MIN, dmin);
    write_reg(szsm_pkg::CFG_DISP_MAX, dmax);
    write_reg(szsm_pkg::CFG_MASK_WIDTH, mw);
    write_reg(szsm_pkg::CFG_MASK_HEIGHT, mh);
    write_reg(szsm_pkg::CFG_CHECK_VAR, cv);
    write_reg(szsm_pkg::CFG_MIN_VAR, mv);
    write_reg(szsm_pkg::CFG_MAX_ZSSD, mz);
    write_reg(szsm_pkg::CFG_MAX_SSD, ms);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fill a patch of both images; the right one is the left shifted plus noise
  task automatic test_fill_frames();
    int r, c, v;
    for (r = 0; r < REG_ROWS; r++)
      for (c = 0; c < REG_COLS; c++)
        send_item(szsm_pkg::FUNC_WR_LEFT, c, r, $urandom_range(0, 255), 1'b1);
    for (r = 0; r < REG_ROWS; r++)
      for (c = 0; c < REG_COLS; c++) begin
        if (c + TRUE_SHIFT < REG_COLS)
          v = (left_img[r*IMG_W + c + TRUE_SHIFT] + $urandom_range(0, 3)) % 256;
        else
          v = $urandom_range(0, 255);
        send_item(szsm_pkg::FUNC_WR_RIGHT, c, r, v, 1'b0);
      end
    for (r = 0; r < 3; r++)
      for (c = EDGE_COL0; c < IMG_W; c++) begin
        send_item(szsm_pkg::FUNC_WR_LEFT, c, r, $urandom_range(0, 255), 1'b0);
        send_item(szsm_pkg::FUNC_WR_RIGHT, c, r, $urandom_range(0, 255), 1'b1);
      end
    drain();
  endtask

  // Field extremes, every status and the special cases
  task automatic test_directed();
    send_item(szsm_pkg::FUNC_MATCH, 15, 7, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 15, 7, 0, 1'b0);
    send_item(szsm_pkg::FUNC_MATCH, 2047, 2047, 255, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 640, 0, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 0, 480, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 0, 7, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 15, 479, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 15, 0, 0, 1'b1);
    // Ignored beats: unused code and writes off the image
    send_item(szsm_pkg::FUNC_UNUSED, 2047, 2047, 255, 1'b1);
    send_item(szsm_pkg::FUNC_WR_LEFT, 2047, 2047, 255, 1'b1);
    send_item(szsm_pkg::FUNC_WR_RIGHT, 640, 480, 0, 1'b0);
    drain();
    // Smallest mask, search clipped at the right image edge
    set_config(0, 5, 1, 1, 0, 0, 16777215, 16777215);
    send_item(szsm_pkg::FUNC_MATCH, 638, 1, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 639, 1, 0, 1'b1);
    send_item(szsm_pkg::FUNC_MATCH, 10, 5, 0, 1'b1);
    drain();
    // Reversed range by one: two columns, no interior minimum
    set_config(3, 2, 3, 2, 0, 0, 10000000, 10000000);
    send_item(szsm_pkg::FUNC_MATCH, 20, 5, 0, 1'b1);
    drain();
    set_config(200, 255, 3, 3, 0, 0, 10000000, 10000000);
    send_item(szsm_pkg::FUNC_MATCH, 10, 7, 0, 1'b1);
    drain();
    set_config(255, 255, 4, 4, 0, 0, 10000000, 10000000);
    send_item(szsm_pkg::FUNC_MATCH, 20, 7, 0, 1'b1);
    drain();
    // Largest mask, widest range
    set_config(0, 255, 15, 15, 0, 0, 10000000, 10000000);
    send_item(szsm_pkg::FUNC_MATCH, 15, 7, 0, 1'b1);
    drain();
    // The variance, ZSSD and SSD acceptance tests each made to fail
    set_config(0, 12, 3, 3, 1, 65535, 16777215, 16777215);
    send_item(szsm_pkg::FUNC_MATCH, 20, 7, 0, 1'b1);
    drain();
    set_config(0, 12, 3, 3, 0, 0, 0, 16777215);
    send_item(szsm_pkg::FUNC_MATCH, 20, 7, 0, 1'b1);
    drain();
    set_config(0, 12, 3, 3, 0, 0, 16777215, 0);
    send_item(szsm_pkg::FUNC_MATCH, 20, 7, 0, 1'b1);
    drain();
  endtask

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16777215;
      2: return $urandom_range(0, 2000);
      3: return $urandom_range(0, 16777215);
      default: return 10000000;
    endcase
  endfunction

  // Random phases: new settings, then mostly well-formed matches in the patch
  task automatic test_random_phases();
    int p, it, cnt, dmin, dmax, mw, mh, mv, hw, hh, sel, x, y;
    for (p = 0; p < 14; p++) begin
      dmin = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 6);
      case ($urandom_range(0, 5))
        0: dmax = 255;
        1: dmax = $urandom_range(0, 255);
        default: dmax = (dmin + $urandom_range(0, 12)) % 256;
      endcase
      if (p == 3) begin
        mw = $urandom_range(12, 15);
        mh = $urandom_range(12, 15);
      end else begin
        mw = $urandom_range(0, 7);
        mh = $urandom_range(0, 7);
      end
      case ($urandom_range(0, 2))
        0: mv = 0;
        1: mv = 65535;
        default: mv = $urandom_range(0, 3000);
      endcase
      set_config(dmin, dmax, mw, mh, $urandom_range(0, 1), mv, pick_limit(), pick_limit());
      in_idle_on = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      hw = odd_window(mw) / 2;
      hh = odd_window(mh) / 2;
      cnt = (p == 3) ? 8 : 33;
      for (it = 0; it < cnt; it++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          x = $urandom_range(hw, REG_COLS - 2 - hw);
          y = $urandom_range(hh, REG_ROWS - 1 - hh);
          send_item(szsm_pkg::FUNC_MATCH, x, y, $urandom_range(0, 255), 1'b1);
        end else if (sel < 80) begin
          send_item(2'($urandom_range(0, 1)), $urandom_range(0, REG_COLS - 1),
                    $urandom_range(0, REG_ROWS - 1), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
        end else if (sel < 85) begin
          send_item(szsm_pkg::FUNC_MATCH, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 255), 1'b0);
        end else if (sel < 90) begin
          send_item(szsm_pkg::FUNC_MATCH, $urandom_range(IMG_W, 2047),
                    $urandom_range(0, 2047), $urandom_range(0, 255), 1'b1);
        end else if (sel < 95) begin
          send_item(szsm_pkg::FUNC_MATCH, $urandom_range(0, hw - 1),
                    $urandom_range(0, IMG_H - 1), $urandom_range(0, 255), 1'b1);
        end else begin
          send_item(($urandom_range(0, 1) != 0) ? szsm_pkg::FUNC_UNUSED
                                                : szsm_pkg::FUNC_WR_LEFT,
                    $urandom_range(IMG_W, 2047), $urandom_range(0, 2047),
                    $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end
  endtask

  // Result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int stall;
    bit got;
    szsm_tb_types::match_res_t act, exp_res;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        got = out_bus.valid && out_bus.ready;
        act.dq = out_bus.disparity_q4;
        act.st = out_bus.status;
        act.sp = out_bus.subpixel_applied;
        @(posedge clk_i);
      end while (!got);
      if (pending_q.size() == 0) begin
        $display("%0t: result beat with none expected: dq %0d status %0d sp %0d",
                 $realtime, act.dq, act.st, act.sp);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (act.st !== exp_res.st) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_res.st, act.st);
          errors++;
        end
        if (act.dq !== exp_res.dq) begin
          $display("%0t: disparity_q4 expected %0d actual %0d", $realtime, exp_res.dq,
                   act.dq);
          errors++;
        end
        if (act.sp !== exp_res.sp) begin
          $display("%0t: subpixel_applied expected %0d actual %0d", $realtime, exp_res.sp,
                   act.sp);
          errors++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    in_bus.valid          <= 1'b0;
    in_bus.func           <= szsm_pkg::FUNC_WR_LEFT;
    in_bus.pos_x          <= '0;
    in_bus.pos_y          <= '0;
    in_bus.pixel          <= '0;
    in_bus.feature_active <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= szsm_pkg::CFG_DISP_MIN;
    cfg_bus.data          <= '0;
    foreach (left_img[i]) left_img[i] = 8'd0;
    foreach (right_img[i]) right_img[i] = 8'd0;
    r_dmin = 8'd0;
    r_dmax = 8'd80;
    r_mw = 4'd11;
    r_mh = 4'd11;
    r_cvar = 1'b0;
    r_minvar = 16'd0;
    r_maxz = 24'd10000000;
    r_maxs = 24'd10000000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_frames();
    test_directed();
    test_random_phases();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
